@@ rtl/ssr_pkg.sv @@
// Shared types and constants for the stream substring replace unit.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package ssr_pkg;

  parameter int DEF_MAX_SEARCH  = 8;
  parameter int DEF_MAX_REPLACE = 8;

  // Bytes seen by one item: up to eight held bytes plus the incoming one.
  parameter int C_BYTES = 9;

  parameter int CFG_AW = 5;
  parameter int CFG_DW = 64;

  parameter logic [63:0] SEARCH_PAT_RST  = 64'h0000_0000_6570_6570; // "pepe"
  parameter logic [3:0]  SEARCH_LEN_RST  = 4'd4;
  parameter logic [63:0] REPLACE_PAT_RST = 64'h0000_0000_4F43_4150; // "PACO"
  parameter logic [3:0]  REPLACE_LEN_RST = 4'd4;

  typedef enum logic [1:0] {
    REG_SEARCH_PAT  = 2'd0,
    REG_SEARCH_LEN  = 2'd1,
    REG_REPLACE_PAT = 2'd2,
    REG_REPLACE_LEN = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] search_pattern;
    logic [3:0]  search_length;
    logic [63:0] replace_pattern;
    logic [3:0]  replace_length;
  } cfg_t;

  // Work list for one item: copy n_copy bytes of cbytes, then n_rep
  // replacement bytes, then the line end marker if marker is set.
  typedef struct packed {
    logic [C_BYTES-1:0][7:0] cbytes;
    logic [3:0]              n_copy;
    logic [3:0]              n_rep;
    logic                    marker;
  } desc_t;

endpackage

@@ rtl/ssr_cfg.sv @@
// Configuration register file with an APB-style slave port.
// Depends on ssr_pkg for register indexes, reset values and the cfg_t bundle.
module ssr_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ssr_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [ssr_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [ssr_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output ssr_pkg::cfg_t              cfg_o
);

  ssr_pkg::cfg_t     cfg_r;
  ssr_pkg::reg_idx_t reg_idx;
  logic              wr_en;

  assign reg_idx    = ssr_pkg::reg_idx_t'(cfg_paddr[4:3]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_o      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.search_pattern  <= ssr_pkg::SEARCH_PAT_RST;
      cfg_r.search_length   <= ssr_pkg::SEARCH_LEN_RST;
      cfg_r.replace_pattern <= ssr_pkg::REPLACE_PAT_RST;
      cfg_r.replace_length  <= ssr_pkg::REPLACE_LEN_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        ssr_pkg::REG_SEARCH_PAT:  cfg_r.search_pattern  <= cfg_pwdata;
        ssr_pkg::REG_SEARCH_LEN:  cfg_r.search_length   <= cfg_pwdata[3:0];
        ssr_pkg::REG_REPLACE_PAT: cfg_r.replace_pattern <= cfg_pwdata;
        ssr_pkg::REG_REPLACE_LEN: cfg_r.replace_length  <= cfg_pwdata[3:0];
        default:                  cfg_r                 <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ssr_pkg::REG_SEARCH_PAT:  cfg_prdata = cfg_r.search_pattern;
      ssr_pkg::REG_SEARCH_LEN:  cfg_prdata = {60'd0, cfg_r.search_length};
      ssr_pkg::REG_REPLACE_PAT: cfg_prdata = cfg_r.replace_pattern;
      ssr_pkg::REG_REPLACE_LEN: cfg_prdata = {60'd0, cfg_r.replace_length};
      default:                  cfg_prdata = '0;
    endcase
  end

endmodule

@@ rtl/ssr_window.sv @@
// Match window: holds the recent bytes of a line, compares against the search
// pattern and builds the work list for each accepted item. Depends on ssr_pkg.
module ssr_window #(
  parameter int MAX_SEARCH  = ssr_pkg::DEF_MAX_SEARCH,
  parameter int MAX_REPLACE = ssr_pkg::DEF_MAX_REPLACE
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ssr_pkg::cfg_t  cfg_i,
  input  logic           accept_i,
  input  logic [7:0]     byte_i,
  input  logic           has_byte_i,
  input  logic           line_end_i,
  output logic           push_o,
  output ssr_pkg::desc_t desc_o
);

  localparam int WD = (MAX_SEARCH < 8) ? MAX_SEARCH : 8;
  localparam int RD = (MAX_REPLACE < 8) ? MAX_REPLACE : 8;

  logic [7:0] win_r [WD];
  logic [7:0] win_nxt [WD];
  logic [3:0] fill_r, fill_nxt;

  logic [ssr_pkg::C_BYTES-1:0][7:0] cb;
  logic [8*ssr_pkg::C_BYTES-1:0]    shifted, rest;
  logic [3:0] len_eff, rep_eff, clen, drop, n_copy, n_rep;
  logic       full, match;

  always_comb begin
    len_eff = cfg_i.search_length;
    if (len_eff == 4'd0) len_eff = 4'd1;
    if (len_eff > 4'(WD)) len_eff = 4'(WD);
    rep_eff = cfg_i.replace_length;
    if (rep_eff > 4'(RD)) rep_eff = 4'(RD);

    // Held bytes followed by the incoming byte.
    cb = '0;
    for (int k = 0; k < WD; k++) begin
      if (4'(k) < fill_r) cb[k] = win_r[k];
    end
    for (int k = 0; k < ssr_pkg::C_BYTES; k++) begin
      if (has_byte_i && 4'(k) == fill_r) cb[k] = byte_i;
    end
    clen = fill_r + {3'd0, has_byte_i};

    // After a shrink of the search length the oldest bytes leave unchanged first.
    drop = (has_byte_i && fill_r >= len_eff) ? (fill_r - len_eff + 4'd1) : 4'd0;
    shifted = cb >> {drop, 3'b000};
    full    = has_byte_i && ((clen - drop) == len_eff);
    match   = full;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < len_eff && shifted[8*k +: 8] != cfg_i.search_pattern[8*k +: 8]) begin
        match = 1'b0;
      end
    end

    if (match) begin
      n_copy = drop;
    end else if (line_end_i) begin
      n_copy = clen;
    end else if (full) begin
      n_copy = drop + 4'd1;
    end else begin
      n_copy = drop;
    end
    n_rep = match ? rep_eff : 4'd0;

    rest = cb >> {n_copy, 3'b000};
    for (int k = 0; k < WD; k++) begin
      win_nxt[k] = rest[8*k +: 8];
    end
    fill_nxt = (line_end_i || match) ? 4'd0 : (clen - n_copy);
  end

  assign desc_o.cbytes = cb;
  assign desc_o.n_copy = n_copy;
  assign desc_o.n_rep  = n_rep;
  assign desc_o.marker = line_end_i;
  assign push_o = accept_i && (n_copy != 4'd0 || n_rep != 4'd0 || line_end_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 4'd0;
    end else if (accept_i) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_i) begin
      win_r <= win_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 4'(WD))
    else $error("window fill beyond its depth");
  a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept_i && line_end_i |=> fill_r == 4'd0)
    else $error("window not empty after a line end");
  a_copy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    accept_i |-> n_copy <= clen)
    else $error("work list copies more bytes than the window holds");
`endif

endmodule

@@ rtl/ssr_emit.sv @@
// Result sequencer: walks one work list a beat at a time into the output
// register. Depends on ssr_pkg for desc_t.
module ssr_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  ssr_pkg::desc_t desc_i,
  input  logic [63:0]    replace_pattern_i,
  output logic           ready_o,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic [1:0]     out_tuser,
  output logic           out_tlast
);

  ssr_pkg::desc_t act_r;
  logic           act_v_r;
  logic [4:0]     idx_r;
  logic           out_v_r;
  logic [7:0]     out_byte_r;
  logic           out_bv_r, out_done_r, out_last_r;

  logic [4:0] total, copy_end;
  logic [2:0] rep_idx;
  logic       emit, last_beat;
  logic [7:0] byte_sel;
  logic       bv_sel, done_sel;

  always_comb begin
    copy_end  = {1'b0, act_r.n_copy};
    total     = copy_end + {1'b0, act_r.n_rep} + {4'd0, act_r.marker};
    last_beat = (idx_r == total - 5'd1);
    emit      = act_v_r && (!out_v_r || out_tready);
    rep_idx   = 3'(idx_r - copy_end);
    if (idx_r < copy_end) begin
      byte_sel = act_r.cbytes[idx_r[3:0]];
      bv_sel   = 1'b1;
      done_sel = 1'b0;
    end else if (idx_r < copy_end + {1'b0, act_r.n_rep}) begin
      byte_sel = replace_pattern_i[{rep_idx, 3'b000} +: 8];
      bv_sel   = 1'b1;
      done_sel = 1'b0;
    end else begin
      byte_sel = 8'h00;
      bv_sel   = 1'b0;
      done_sel = 1'b1;
    end
  end

  assign ready_o = !act_v_r || (emit && last_beat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_v_r <= 1'b0;
      idx_r   <= 5'd0;
      out_v_r <= 1'b0;
    end else begin
      if (push_i) begin
        act_v_r <= 1'b1;
        idx_r   <= 5'd0;
      end else if (emit && last_beat) begin
        act_v_r <= 1'b0;
      end else if (emit) begin
        idx_r <= idx_r + 5'd1;
      end
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      act_r <= desc_i;
    end
    if (emit) begin
      out_byte_r <= byte_sel;
      out_bv_r   <= bv_sel;
      out_done_r <= done_sel;
      out_last_r <= last_beat;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_last_r, out_bv_r};
  assign out_tlast  = out_done_r;

`ifndef SYNTHESIS
  a_idx_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    act_v_r |-> idx_r < total)
    else $error("sequencer index past the end of its work list");
  a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> ready_o)
    else $error("work list loaded while the sequencer is busy");
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit && done_sel |-> last_beat)
    else $error("line end marker is not the final beat of its item");
`endif

endmodule

@@ rtl/stream_substring_replace_unit.sv @@
// Top level of the streaming find-and-replace unit.
// Depends on ssr_pkg, ssr_cfg, ssr_window and ssr_emit.
//
//   Channel   Direction  Handshake             Payload
//   in_       slave      in_tvalid/in_tready   tdata=in_byte, tuser=has_byte, tlast=line_end
//   out_      master     out_tvalid/out_tready tdata=out_byte, tuser={last,byte_valid},
//                                              tlast=line_done
//   cfg_      APB slave  psel/penable/pready   64-bit registers at byte address 8*index
//
// Items that give zero or one result beat stream at one per clock while the
// output register is free to move on out_tready. An item that gives N beats
// (up to 16) holds the result sequencer, one beat per cycle while out_tready
// allows, and the input stalls until its last beat moves into the output
// register. The output register lets the next item in while the final beat of
// the previous one still waits on out_tready. Synchronous active-low reset
// empties the window and the sequencer and loads the default "pepe" -> "PACO" setup.
module stream_substring_replace_unit #(
  parameter int MAX_SEARCH  = ssr_pkg::DEF_MAX_SEARCH,
  parameter int MAX_REPLACE = ssr_pkg::DEF_MAX_REPLACE
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input beats: one byte of a line or a bare line end.
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] in_byte
  input  logic                       in_tuser,   // [0] has_byte
  input  logic                       in_tlast,   // line_end
  // Result beats.
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // [7:0] out_byte
  output logic [1:0]                 out_tuser,  // [0] byte_valid, [1] last
  output logic                       out_tlast,  // line_done
  // Configuration.
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ssr_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [ssr_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [ssr_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  ssr_pkg::cfg_t  cfg;
  ssr_pkg::desc_t desc;
  logic           push;
  logic           accept;

  // The window updates on every accepted beat; the sequencer gets a work
  // list only when the beat produces at least one result.
  assign accept = in_tvalid && in_tready;

  ssr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  ssr_window #(
    .MAX_SEARCH  (MAX_SEARCH),
    .MAX_REPLACE (MAX_REPLACE)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .accept_i   (accept),
    .byte_i     (in_tdata),
    .has_byte_i (in_tuser),
    .line_end_i (in_tlast),
    .push_o     (push),
    .desc_o     (desc)
  );

  // Replacement bytes are read from the live register; the user must change
  // configuration only while the unit is idle, which the block does not enforce.
  ssr_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .push_i            (push),
    .desc_i            (desc),
    .replace_pattern_i (cfg.replace_pattern),
    .ready_o           (in_tready),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata),
    .out_tuser         (out_tuser),
    .out_tlast         (out_tlast)
  );

endmodule
